[hw/rtl/tags_pkg.sv]
package tags_pkg;

  // dividend, divisor and accumulator widths of the gradient datapath
  localparam int NUM_W  = 86;
  localparam int DEN_W  = 34;
  localparam int ACC_W  = 84;
  localparam int PROD_W = 80;
  localparam int MAG_W  = 64;
  localparam int BMAG_W = 16;
  localparam int DET_W  = 34;

  localparam logic [1:0] ATTR_U     = 2'd0;
  localparam logic [1:0] ATTR_V     = 2'd1;
  localparam logic [1:0] ATTR_RECIP = 2'd2;
  localparam logic [1:0] ATTR_DEPTH = 2'd3;

  localparam logic [1:0] VTX_MAX = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DEPTH,
    OP_RECIP,
    OP_UOVW,
    OP_VOVW,
    OP_MAC,
    OP_DET,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] vtx;
    logic [1:0] attr;
    logic       use_pos;
    logic       a_vtx;
    logic       b_y;
    logic       b_vtx;
    logic       sub;
    logic       clr;
    logic       axis_y;
    logic       wr;
    logic [1:0] wr_idx;
    logic [1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic det_zero;
  } dp_stat_t;

endpackage

[hw/rtl/triangle_attribute_gradient_setup_top.sv]
// channel  | handshake            | word
// vertex   | vtx_valid/vtx_stall  | pos_x pos_y depth_z clip_w tex_u tex_v
// result   | res_valid/res_stall  | attribute_id value_* step_along_* degenerate last
//
// first and second vertex of a triangle: only stored, they start no computation
// third vertex: starts the setup, whose time is set by the 86-step restoring divider
// run up to 17 times (up to 9 if degenerate) and the 16-step serial multiplier
// results leave one word per cycle while not stalled; the next triangle's first two
// vertices are taken while results wait, its third once all four results are gone
// synchronous reset clears the vertex count and all control state
module triangle_attribute_gradient_setup_top
  import tags_pkg::*;
#(
  parameter int RESULT_FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vtx_valid,
  output logic               vtx_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [31:0] depth_z,
  input  logic        [31:0] clip_w,
  input  logic signed [15:0] tex_u,
  input  logic signed [15:0] tex_v,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         attribute_id,
  output logic signed [63:0] value_first,
  output logic signed [63:0] value_second,
  output logic signed [63:0] value_third,
  output logic signed [63:0] step_along_x,
  output logic signed [63:0] step_along_y,
  output logic               degenerate,
  output logic               last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tags_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_id    (attribute_id),
    .stat      (stat),
    .cmd       (cmd)
  );

  tags_dp #(
    .FRAC_BITS (RESULT_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .depth_z      (depth_z),
    .clip_w       (clip_w),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .value_first  (value_first),
    .value_second (value_second),
    .value_third  (value_third),
    .step_along_x (step_along_x),
    .step_along_y (step_along_y),
    .degenerate   (degenerate)
  );

  assign last = (attribute_id == ATTR_DEPTH);

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && degenerate) |-> (step_along_x == '0) && (step_along_y == '0))
    else $error("degenerate result with nonzero step");

  a_vtx_idle_dp: assert property (@(posedge clk) disable iff (rst)
    (vtx_valid && !vtx_stall) |-> !stat.busy)
    else $error("vertex taken while datapath busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && last) |=> !res_valid)
    else $error("result after last word of triangle");

  a_id_order: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !last) |=>
      res_valid && (attribute_id == $past(attribute_id) + 2'd1))
    else $error("attribute ids out of order");

endmodule

[hw/rtl/tags_div.sv]
module tags_div
  import tags_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[DEN_W+1]) begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/tags_dp.sv]
module tags_dp
  import tags_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [31:0] depth_z,
  input  logic        [31:0] clip_w,
  input  logic signed [15:0] tex_u,
  input  logic signed [15:0] tex_v,
  output logic signed [63:0] value_first,
  output logic signed [63:0] value_second,
  output logic signed [63:0] value_third,
  output logic signed [63:0] step_along_x,
  output logic signed [63:0] step_along_y,
  output logic               degenerate
);

  localparam logic signed [63:0] SAT_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {M_IDLE, M_PREP, M_MUL, M_ACC} mac_state_t;

  logic signed [15:0] px [3];
  logic signed [15:0] py [3];
  logic signed [15:0] tu [3];
  logic signed [15:0] tv [3];
  logic signed [31:0] pz [3];
  logic        [31:0] pw [3];

  logic signed [63:0] val [4][3];
  logic signed [63:0] sx [4];
  logic signed [63:0] sy [4];
  logic               degen;
  logic signed [DET_W-1:0] det;

  mac_state_t          mac_state;
  logic signed [63:0]  ca, c2;
  logic signed [15:0]  ba, b2;
  logic [MAG_W-1:0]    mag_a;
  logic [BMAG_W-1:0]   mag_b;
  logic [PROD_W-1:0]   prod;
  logic                mneg, msub, mclr;
  logic [3:0]          mcnt;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_base;

  logic signed [64:0] diff_a;
  logic signed [16:0] diff_b;
  logic [64:0]        diff_a_abs;
  logic [16:0]        diff_b_abs;
  logic [ACC_W-1:0]   acc_mag;
  logic [DET_W-1:0]   det_mag;

  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_q;
  op_t              d_op;
  logic [1:0]       d_vtx;
  logic [1:0]       d_attr;
  logic             d_axis_y;
  logic             d_neg;
  logic signed [63:0] q_signed;
  logic signed [63:0] q_sat;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  assign diff_a     = {ca[63], ca} - {c2[63], c2};
  assign diff_b     = {ba[15], ba} - {b2[15], b2};
  assign diff_a_abs = diff_a[64] ? -diff_a : diff_a;
  assign diff_b_abs = diff_b[16] ? -diff_b : diff_b;
  assign acc_mag    = acc[ACC_W-1] ? -acc : acc;
  assign det_mag    = det[DET_W-1] ? -det : det;
  assign acc_base   = mclr ? '0 : acc;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(pw[cmd.vtx]);
    case (cmd.op)
      OP_RECIP: begin
        div_start = (pw[cmd.vtx] != '0);
        div_num   = NUM_W'(1) << (FRAC_BITS + 16);
      end
      OP_UOVW: begin
        div_start = (pw[cmd.vtx] != '0);
        div_num   = NUM_W'(abs16(tu[cmd.vtx])) << (FRAC_BITS + 4);
      end
      OP_VOVW: begin
        div_start = (pw[cmd.vtx] != '0);
        div_num   = NUM_W'(abs16(tv[cmd.vtx])) << (FRAC_BITS + 4);
      end
      OP_STEP: begin
        // positions carry 4 fraction bits and the determinant 8
        div_start = 1'b1;
        div_num   = NUM_W'(acc_mag) << 4;
        div_den   = DEN_W'(det_mag);
      end
      default: ;
    endcase
  end

  tags_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign q_signed = d_neg ? -$signed(div_q[63:0]) : $signed(div_q[63:0]);

  always_comb begin
    if (!d_neg) begin
      q_sat = (div_q[NUM_W-1:63] != '0) ? SAT_MAX : $signed(div_q[63:0]);
    end else if ((div_q[NUM_W-1:64] != '0) || (div_q[63] && (div_q[62:0] != '0))) begin
      q_sat = SAT_MIN;
    end else begin
      q_sat = -$signed(div_q[63:0]);
    end
  end

  // serial multiply-accumulate of one difference product
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_state <= M_IDLE;
    end else begin
      case (mac_state)
        M_IDLE: begin
          if (cmd.op == OP_MAC) begin
            mac_state <= M_PREP;
          end
        end
        M_PREP: begin
          mac_state <= M_MUL;
        end
        M_MUL: begin
          if (mcnt == 4'd15) begin
            mac_state <= M_ACC;
          end
        end
        default: begin
          mac_state <= M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (mac_state)
      M_IDLE: begin
        if (cmd.op == OP_MAC) begin
          ca <= cmd.use_pos ? 64'(px[{1'b0, cmd.a_vtx}]) : val[cmd.attr][{1'b0, cmd.a_vtx}];
          c2 <= cmd.use_pos ? 64'(px[VTX_MAX]) : val[cmd.attr][VTX_MAX];
          ba <= cmd.b_y ? py[{1'b0, cmd.b_vtx}] : px[{1'b0, cmd.b_vtx}];
          b2 <= cmd.b_y ? py[VTX_MAX] : px[VTX_MAX];
          msub <= cmd.sub;
          mclr <= cmd.clr;
        end
      end
      M_PREP: begin
        mag_a <= diff_a_abs[MAG_W-1:0];
        mag_b <= diff_b_abs[BMAG_W-1:0];
        mneg  <= diff_a[64] ^ diff_b[16] ^ msub;
        prod  <= '0;
        mcnt  <= '0;
      end
      M_MUL: begin
        prod  <= {prod[PROD_W-2:0], 1'b0} + (mag_b[BMAG_W-1] ? PROD_W'(mag_a) : '0);
        mag_b <= {mag_b[BMAG_W-2:0], 1'b0};
        mcnt  <= mcnt + 4'd1;
      end
      default: begin
        acc <= mneg ? (acc_base - $signed(ACC_W'(prod))) : (acc_base + $signed(ACC_W'(prod)));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      px[cmd.wr_idx] <= pos_x;
      py[cmd.wr_idx] <= pos_y;
      pz[cmd.wr_idx] <= depth_z;
      pw[cmd.wr_idx] <= clip_w;
      tu[cmd.wr_idx] <= tex_u;
      tv[cmd.wr_idx] <= tex_v;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (d_op)
        OP_RECIP: val[ATTR_RECIP][d_vtx] <= $signed(div_q[63:0]);
        OP_UOVW:  val[ATTR_U][d_vtx] <= q_signed;
        OP_VOVW:  val[ATTR_V][d_vtx] <= q_signed;
        default: begin
          if (d_axis_y) begin
            sy[d_attr] <= q_sat;
          end else begin
            sx[d_attr] <= q_sat;
          end
        end
      endcase
    end else begin
      case (cmd.op)
        OP_DEPTH: begin
          val[ATTR_DEPTH][cmd.vtx] <= 64'(pz[cmd.vtx]) <<< (FRAC_BITS - 16);
        end
        OP_RECIP: begin
          if (pw[cmd.vtx] == '0) begin
            val[ATTR_RECIP][cmd.vtx] <= SAT_MAX;
          end
        end
        OP_UOVW: begin
          if (pw[cmd.vtx] == '0) begin
            val[ATTR_U][cmd.vtx] <= tu[cmd.vtx][15] ? SAT_MIN :
                                    (tu[cmd.vtx] != '0) ? SAT_MAX : '0;
          end
        end
        OP_VOVW: begin
          if (pw[cmd.vtx] == '0) begin
            val[ATTR_V][cmd.vtx] <= tv[cmd.vtx][15] ? SAT_MIN :
                                    (tv[cmd.vtx] != '0) ? SAT_MAX : '0;
          end
        end
        OP_DET: begin
          det <= acc[DET_W-1:0];
          if (acc == '0) begin
            for (int i = 0; i < 4; i++) begin
              sx[i] <= '0;
              sy[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      d_op     <= cmd.op;
      d_vtx    <= cmd.vtx;
      d_attr   <= cmd.attr;
      d_axis_y <= cmd.axis_y;
      case (cmd.op)
        OP_UOVW: d_neg <= tu[cmd.vtx][15];
        OP_VOVW: d_neg <= tv[cmd.vtx][15];
        OP_STEP: d_neg <= acc[ACC_W-1] ^ det[DET_W-1];
        default: d_neg <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degen <= 1'b0;
    end else if (cmd.op == OP_DET) begin
      degen <= (acc == '0);
    end
  end

  assign stat.busy     = (mac_state != M_IDLE) || div_busy || div_done;
  assign stat.det_zero = degen;

  assign value_first  = val[cmd.out_idx][0];
  assign value_second = val[cmd.out_idx][1];
  assign value_third  = val[cmd.out_idx][2];
  assign step_along_x = sx[cmd.out_idx];
  assign step_along_y = sy[cmd.out_idx];
  assign degenerate   = degen;

endmodule

[hw/rtl/tags_ctrl.sv]
module tags_ctrl
  import tags_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       vtx_valid,
  output logic       vtx_stall,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] res_id,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;
  typedef enum logic [2:0] {G_DEPTH, G_RECIP, G_UOVW, G_VOVW, G_DET, G_GRAD} group_t;

  localparam logic [2:0] STEP_VTX_END  = 3'd2;
  localparam logic [2:0] STEP_DET_END  = 3'd2;
  localparam logic [2:0] STEP_GRAD_END = 3'd5;

  state_t     state;
  group_t     grp;
  logic [2:0] step;
  logic [1:0] attr;
  logic [1:0] count;
  logic [1:0] out_idx;
  logic       vtx_take;
  logic       res_take;

  // the third vertex waits until the previous triangle is fully delivered
  assign vtx_stall = !((state == S_IDLE) || ((state == S_OUT) && (count != VTX_MAX)));
  assign vtx_take  = vtx_valid && !vtx_stall;
  assign res_valid = (state == S_OUT);
  assign res_take  = res_valid && !res_stall;
  assign res_id    = out_idx;

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.wr      = vtx_take;
    cmd.wr_idx  = count;
    cmd.out_idx = out_idx;
    cmd.vtx     = step[1:0];
    cmd.attr    = attr;
    if (state == S_ISSUE) begin
      case (grp)
        G_DEPTH: cmd.op = OP_DEPTH;
        G_RECIP: cmd.op = OP_RECIP;
        G_UOVW:  cmd.op = OP_UOVW;
        G_VOVW:  cmd.op = OP_VOVW;
        G_DET: begin
          // det = (x1-x2)(y0-y2) - (x0-x2)(y1-y2)
          cmd.use_pos = 1'b1;
          cmd.b_y     = 1'b1;
          case (step)
            3'd0: begin
              cmd.op    = OP_MAC;
              cmd.a_vtx = 1'b1;
              cmd.clr   = 1'b1;
            end
            3'd1: begin
              cmd.op    = OP_MAC;
              cmd.b_vtx = 1'b1;
              cmd.sub   = 1'b1;
            end
            default: cmd.op = OP_DET;
          endcase
        end
        default: begin
          case (step)
            3'd0: begin
              cmd.op    = OP_MAC;
              cmd.a_vtx = 1'b1;
              cmd.b_y   = 1'b1;
              cmd.clr   = 1'b1;
            end
            3'd1: begin
              cmd.op    = OP_MAC;
              cmd.b_y   = 1'b1;
              cmd.b_vtx = 1'b1;
              cmd.sub   = 1'b1;
            end
            3'd2: cmd.op = OP_STEP;
            3'd3: begin
              // y step numerator, already negated
              cmd.op    = OP_MAC;
              cmd.b_vtx = 1'b1;
              cmd.clr   = 1'b1;
            end
            3'd4: begin
              cmd.op    = OP_MAC;
              cmd.a_vtx = 1'b1;
              cmd.sub   = 1'b1;
            end
            default: begin
              cmd.op     = OP_STEP;
              cmd.axis_y = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      grp     <= G_DEPTH;
      step    <= '0;
      attr    <= '0;
      count   <= '0;
      out_idx <= '0;
    end else begin
      if (vtx_take) begin
        count <= (count == VTX_MAX) ? 2'd0 : count + 2'd1;
      end
      case (state)
        S_IDLE: begin
          if (vtx_take && (count == VTX_MAX)) begin
            state <= S_ISSUE;
            grp   <= G_DEPTH;
            step  <= '0;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!stat.busy) begin
            state <= S_ISSUE;
            case (grp)
              G_DEPTH, G_RECIP, G_UOVW, G_VOVW: begin
                if (step == STEP_VTX_END) begin
                  step <= '0;
                  case (grp)
                    G_DEPTH: grp <= G_RECIP;
                    G_RECIP: grp <= G_UOVW;
                    G_UOVW:  grp <= G_VOVW;
                    default: grp <= G_DET;
                  endcase
                end else begin
                  step <= step + 3'd1;
                end
              end
              G_DET: begin
                if (step == STEP_DET_END) begin
                  step <= '0;
                  attr <= ATTR_U;
                  if (stat.det_zero) begin
                    state   <= S_OUT;
                    out_idx <= ATTR_U;
                  end else begin
                    grp <= G_GRAD;
                  end
                end else begin
                  step <= step + 3'd1;
                end
              end
              default: begin
                if (step == STEP_GRAD_END) begin
                  step <= '0;
                  if (attr == ATTR_DEPTH) begin
                    state   <= S_OUT;
                    out_idx <= ATTR_U;
                  end else begin
                    attr <= attr + 2'd1;
                  end
                end else begin
                  step <= step + 3'd1;
                end
              end
            endcase
          end
        end
        default: begin
          if (res_take) begin
            if (out_idx == ATTR_DEPTH) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 2'd1;
            end
          end
        end
      endcase
    end
  end

endmodule
